// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
// Both macros assume a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LNPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LNPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lnps_pkg.sv -----
// Shared types, constants and constant functions of the log-normal peak sampler.
// It has no dependencies.
package lnps_pkg;

    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
    } t_ctl;

    typedef enum logic [2:0] {
        REG_START_POS     = 3'd0,
        REG_END_POS       = 3'd1,
        REG_SAMPLE_STEP   = 3'd2,
        REG_PEAK_HEIGHT   = 3'd3,
        REG_RETENTION_POS = 3'd4,
        REG_CURVE_SCALE   = 3'd5,
        REG_SHAPE_COEFF   = 3'd6
    } t_reg_index;

    localparam logic [31:0] LN2_Q28    = 32'd186065279;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [48:0] ONE_Q28    = 49'h1000_0000;
    localparam int          EXP_STAGES = 16;

    function automatic logic [63:0] lnps_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Factor 2^-(2^-j) in Q.30, the j-th square root of one half.
    function automatic logic [30:0] lnps_root(input int j);
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int k = 0; k < j; k++) begin
            r = lnps_isqrt(r << 30);
        end
        return r[30:0];
    endfunction

endpackage

// ----- design/log_normal_peak_sampler.sv -----
// Top level of the log-normal peak sampler: configuration registers, stall
// control and the position, log and exponential pipelines. Depends on
// lnps_pkg and assert_macros.svh.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat is stalled, and bubbles are not squeezed out.
// Reset: synchronous; clears all valid bits and loads register reset values.
`include "assert_macros.svh"
module log_normal_peak_sampler #(
    parameter int INDEX_BITS     = 16,
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_sample_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sample_value,
    output logic        o_is_last
);
    import lnps_pkg::*;

    logic [31:0] r_start_pos, r_end_pos, r_sample_step, r_peak_height;
    logic [31:0] r_retention_pos, r_curve_scale, r_shape_coeff;
    logic [31:0] r_cl;
    logic [59:0] clp;
    logic        en;

    t_ctl        pos_ctl, log_ctl, exp_ctl;
    logic [48:0] u;
    logic [20:0] y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos     <= 32'd0;
            r_end_pos       <= 32'd65536;
            r_sample_step   <= 32'd65536;
            r_peak_height   <= 32'd100000;
            r_retention_pos <= 32'd78643200;
            r_curve_scale   <= 32'd257698038;
            r_shape_coeff   <= 32'd72039290;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_POS:     r_start_pos     <= i_cfg_data;
                REG_END_POS:       r_end_pos       <= i_cfg_data;
                REG_SAMPLE_STEP:   r_sample_step   <= i_cfg_data;
                REG_PEAK_HEIGHT:   r_peak_height   <= i_cfg_data;
                REG_RETENTION_POS: r_retention_pos <= i_cfg_data;
                REG_CURVE_SCALE:   r_curve_scale   <= i_cfg_data;
                REG_SHAPE_COEFF:   r_shape_coeff   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign clp = 60'(r_shape_coeff) * 60'(LN2_Q28);

    always_ff @(posedge i_clk) begin
        r_cl <= clp[59:28];
    end

    assign o_valid = exp_ctl.valid;
    assign o_is_last = exp_ctl.last;
    assign en      = !(exp_ctl.valid && i_stall);
    assign o_stall = !en;

    lnps_pos #(.INDEX_BITS(INDEX_BITS)) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_valid),
        .i_sample_index (i_sample_index),
        .i_start_pos    (r_start_pos),
        .i_end_pos      (r_end_pos),
        .i_sample_step  (r_sample_step),
        .i_retention_pos(r_retention_pos),
        .i_curve_scale  (r_curve_scale),
        .o_ctl          (pos_ctl),
        .o_u            (u)
    );

    lnps_log #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (pos_ctl),
        .i_u     (u),
        .i_cl    (r_cl),
        .o_ctl   (log_ctl),
        .o_y     (y)
    );

    lnps_exp u_exp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_ctl          (log_ctl),
        .i_y            (y),
        .i_peak_height  (r_peak_height),
        .o_ctl          (exp_ctl),
        .o_sample_value (o_sample_value)
    );

    `LNPS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_sample_value) && $stable(o_is_last), "stalled output beat changed")

endmodule

// ----- design/lnps_pos.sv -----
// Position stages: sample position, last-sample flag, zero flag and the log argument u.
// Depends on lnps_pkg.
module lnps_pos #(
    parameter int INDEX_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [15:0]     i_sample_index,
    input  logic [31:0]     i_start_pos,
    input  logic [31:0]     i_end_pos,
    input  logic [31:0]     i_sample_step,
    input  logic [31:0]     i_retention_pos,
    input  logic [31:0]     i_curve_scale,
    output lnps_pkg::t_ctl  o_ctl,
    output logic [48:0]     o_u
);
    import lnps_pkg::*;

    localparam int PW = INDEX_BITS + 33;

    logic [INDEX_BITS-1:0] idx;
    logic [PW-1:0]         raw;
    logic [PW-1:0]         prev_raw;
    logic [31:0]           n_pos;
    logic [31:0]           prev_pos;
    logic [63:0]           tprod;

    t_ctl                  r_ca, r_cb, r_cc, r_cd, r_ce;
    logic [INDEX_BITS+31:0] r_prod;
    logic                  r_izero;
    logic [31:0]           r_pos;
    logic [31:0]           r_dmag;
    logic                  r_neg_c, r_neg_d;
    logic [47:0]           r_t;
    logic [48:0]           r_u;

    assign idx      = INDEX_BITS'(i_sample_index);
    assign raw      = PW'(i_start_pos) + PW'(r_prod);
    assign prev_raw = raw - PW'(i_sample_step);
    assign n_pos    = (raw > PW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : raw[31:0];
    assign prev_pos = (prev_raw > PW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : prev_raw[31:0];
    assign tprod    = 64'(r_dmag) * 64'(i_curve_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= '0;
            r_cb <= '0;
            r_cc <= '0;
            r_cd <= '0;
            r_ce <= '0;
        end else if (i_en) begin
            r_ca <= '{valid: i_valid, last: 1'b0, zero: 1'b0};
            r_cb <= '{valid: r_ca.valid,
                      last: (n_pos >= i_end_pos) && (r_izero || (prev_pos < i_end_pos)),
                      zero: 1'b0};
            r_cc <= r_cb;
            r_cd <= r_cc;
            r_ce <= '{valid: r_cd.valid, last: r_cd.last,
                      zero: r_neg_d && (r_t >= 48'(ONE_Q28))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= (INDEX_BITS+32)'(idx) * (INDEX_BITS+32)'(i_sample_step);
            r_izero <= (idx == '0);
            r_pos   <= n_pos;
            r_neg_c <= r_pos < i_retention_pos;
            r_dmag  <= (r_pos < i_retention_pos) ? i_retention_pos - r_pos
                                                 : r_pos - i_retention_pos;
            r_neg_d <= r_neg_c;
            r_t     <= tprod[63:16];
            if (r_neg_d) begin
                r_u <= (r_t >= 48'(ONE_Q28)) ? 49'd1 : ONE_Q28 - 49'(r_t);
            end else begin
                r_u <= ONE_Q28 + 49'(r_t);
            end
        end
    end

    assign o_ctl = r_ce;
    assign o_u   = r_u;

endmodule

// ----- design/lnps_log.sv -----
// Log stages: log2 of u by leading-one search and repeated squaring, then the
// exponent y = c*ln2*log2(u)^2 in Q.16. Depends on lnps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lnps_log #(
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  lnps_pkg::t_ctl  i_ctl,
    input  logic [48:0]     i_u,
    input  logic [31:0]     i_cl,
    output lnps_pkg::t_ctl  o_ctl,
    output logic [20:0]     o_y
);
    import lnps_pkg::*;

    localparam int F  = LOG_TABLE_BITS;
    localparam int LW = F + 6;
    localparam int SW = F + 12;

    t_ctl         r_c0;
    t_ctl         r_c1;
    logic [48:0]  r_u0;
    logic [48:0]  r_u1;
    logic [5:0]   r_e0;
    logic [5:0]   n_e;
    logic [48:0]  norm;

    t_ctl         r_c [0:F];
    logic [30:0]  r_m [0:F];
    logic [5:0]   r_e [0:F];
    logic [F-1:0] r_fr [0:F];

    t_ctl         r_cm, r_cs, r_cy;
    logic [LW-1:0] r_mag;
    logic [SW-1:0] r_sq;
    logic [20:0]   r_y;
    logic [LW-1:0] n_mag;
    logic [2*LW-1:0] sqp;
    logic [SW+31:0]  yp;

    always_comb begin
        n_e = 6'd0;
        for (int k = 0; k < 49; k++) begin
            if (r_u0[k] == 1'b0) begin
                n_e = n_e;
            end else begin
                n_e = 6'(k);
            end
        end
    end

    assign norm = (r_e0 > 6'd30) ? (r_u1 >> (r_e0 - 6'd30)) : (r_u1 << (6'd30 - r_e0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
            r_c[0] <= '0;
        end else if (i_en) begin
            r_c0 <= i_ctl;
            r_c1 <= r_c0;
            r_c[0] <= r_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u0    <= i_u;
            r_u1    <= r_u0;
            r_e0    <= n_e;
            r_m[0]  <= norm[30:0];
            r_e[0]  <= r_e0;
            r_fr[0] <= '0;
        end
    end

    for (genvar s = 1; s <= F; s++) begin : g_sq
        logic [61:0] p;
        assign p = 62'(r_m[s-1]) * 62'(r_m[s-1]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c[s] <= '0;
            end else if (i_en) begin
                r_c[s] <= r_c[s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e[s]  <= r_e[s-1];
                r_fr[s] <= {r_fr[s-1][F-2:0], p[61]};
                r_m[s]  <= p[61] ? p[61:31] : p[60:30];
            end
        end
    end

    always_comb begin
        if (r_e[F] >= 6'd28) begin
            n_mag = {LW'(r_e[F] - 6'd28)} << F | LW'(r_fr[F]);
        end else begin
            n_mag = (LW'(6'd28 - r_e[F]) << F) - LW'(r_fr[F]);
        end
    end

    assign sqp = (2*LW)'(r_mag) * (2*LW)'(r_mag);
    assign yp  = (SW+32)'(i_cl) * (SW+32)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm <= '0;
            r_cs <= '0;
            r_cy <= '0;
        end else if (i_en) begin
            r_cm <= r_c[F];
            r_cs <= r_cm;
            r_cy <= '{valid: r_cs.valid, last: r_cs.last,
                      zero: r_cs.zero || (|yp[SW+31:12+F+21])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
            r_sq  <= SW'(sqp >> F);
            r_y   <= yp[12+F+20:12+F];
        end
    end

    assign o_ctl = r_cy;
    assign o_y   = r_y;

    `LNPS_ASSERT_NOW(a_norm_msb, r_c[0].valid, r_m[0][30], "normalized mantissa lost its leading one")

endmodule

// ----- design/lnps_exp.sv -----
// Exponential stages: 2^-y as a product of constant roots and a right shift, scaled by the height.
// Depends on lnps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lnps_exp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  lnps_pkg::t_ctl  i_ctl,
    input  logic [20:0]     i_y,
    input  logic [31:0]     i_peak_height,
    output lnps_pkg::t_ctl  o_ctl,
    output logic [31:0]     o_sample_value
);
    import lnps_pkg::*;

    t_ctl        r_c [0:EXP_STAGES];
    logic [30:0] r_m [0:EXP_STAGES];
    logic [20:0] r_y [0:EXP_STAGES];

    t_ctl        r_cp, r_co;
    logic [62:0] r_prod;
    logic [4:0]  r_yi;
    logic [31:0] r_val;
    logic [62:0] shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0] <= '0;
        end else if (i_en) begin
            r_c[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= ONE_Q30;
            r_y[0] <= i_y;
        end
    end

    for (genvar j = 1; j <= EXP_STAGES; j++) begin : g_root
        localparam logic [30:0] ROOT = lnps_root(j);
        logic [61:0] p;
        assign p = 62'(r_m[j-1]) * 62'(ROOT);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c[j] <= '0;
            end else if (i_en) begin
                r_c[j] <= r_c[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[j] <= r_y[j-1];
                r_m[j] <= r_y[j-1][EXP_STAGES-j] ? p[60:30] : r_m[j-1];
            end
        end
    end

    assign shifted = r_prod >> (6'd30 + 6'(r_yi));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp <= '0;
            r_co <= '0;
        end else if (i_en) begin
            r_cp <= r_c[EXP_STAGES];
            r_co <= r_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 63'(i_peak_height) * 63'(r_m[EXP_STAGES]);
            r_yi   <= r_y[EXP_STAGES][20:16];
            r_val  <= r_cp.zero ? 32'd0 : shifted[31:0];
        end
    end

    assign o_ctl          = r_co;
    assign o_sample_value = r_val;

    `LNPS_ASSERT_NOW(a_factor_max, r_c[EXP_STAGES].valid, r_m[EXP_STAGES] <= ONE_Q30, "exponential factor exceeds one")

endmodule
